>>> hw/rtl/mand_pkg.sv
// ----------------------------------------------------------------------------
// mand_pkg
// Shared types and constants for the escape-time pixel evaluator.
// ----------------------------------------------------------------------------
package mand_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_MIN_X    = 3'd0;
  localparam logic [IDX_W-1:0] REG_MIN_Y    = 3'd1;
  localparam logic [IDX_W-1:0] REG_STEP_X   = 3'd2;
  localparam logic [IDX_W-1:0] REG_STEP_Y   = 3'd3;
  localparam logic [IDX_W-1:0] REG_ITER_CAP = 3'd4;

  typedef struct packed {
    logic [10:0] col;
    logic [9:0]  row;
  } pixel_in_t;

  typedef struct packed {
    logic [15:0] iteration_count;
    logic        in_set;
  } pixel_out_t;

  // token handed between cells
  typedef struct packed {
    logic              busy;
    logic              done;
    logic [WORD_W-1:0] zr;
    logic [WORD_W-1:0] zi;
    logic [CNT_W-1:0]  count;
  } cell_tok_t;

  function automatic logic [WORD_W-1:0] sat32(input logic signed [65:0] v);
    if (v > 66'sh0_7FFF_FFFF) begin
      sat32 = 32'h7FFF_FFFF;
    end else if (v < -66'sh0_8000_0000) begin
      sat32 = 32'h8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

>>> hw/rtl/mand_cell.sv
// ----------------------------------------------------------------------------
// mand_cell
// One z = z*z + c step: products, then the add, then the escape test, each registered.
// ----------------------------------------------------------------------------
module mand_cell #(
  parameter int unsigned FRAC_BITS = 26
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mand_pkg::cell_tok_t           tok_in,
  input  logic [mand_pkg::WORD_W-1:0]   cr,
  input  logic [mand_pkg::WORD_W-1:0]   ci,
  input  logic [mand_pkg::CNT_W-1:0]    iter_cap,
  output mand_pkg::cell_tok_t           tok_out
);
  import mand_pkg::*;

  // stage 1: squares and cross product
  logic signed [63:0] rr_p, ii_p, ri_p;
  logic               s1_busy, s1_done;
  logic [CNT_W-1:0]   s1_count;
  logic [WORD_W-1:0]  s1_zr, s1_zi;

  // stage 2: new z, then escape products
  logic signed [65:0] nzr_w, nzi_w;
  logic [WORD_W-1:0]  nzr, nzi;
  logic signed [63:0] erp, eip;
  logic signed [65:0] esum;
  logic               escaped;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_busy <= 1'b0;
    end else begin
      s1_busy <= tok_in.busy;
    end
    s1_done  <= tok_in.done;
    s1_count <= tok_in.count;
    s1_zr    <= tok_in.zr;
    s1_zi    <= tok_in.zi;
    rr_p     <= $signed(tok_in.zr) * $signed(tok_in.zr);
    ii_p     <= $signed(tok_in.zi) * $signed(tok_in.zi);
    ri_p     <= $signed(tok_in.zr) * $signed(tok_in.zi);
  end

  always_comb begin
    nzr_w = 66'(rr_p >>> FRAC_BITS) - 66'(ii_p >>> FRAC_BITS) + 66'($signed(cr));
    nzi_w = 66'(ri_p >>> (FRAC_BITS - 1)) + 66'($signed(ci));
    nzr   = sat32(nzr_w);
    nzi   = sat32(nzi_w);
  end

  // stage 2 registers
  logic               s2_busy, s2_done;
  logic [CNT_W-1:0]   s2_count;
  logic [WORD_W-1:0]  s2_zr, s2_zi;
  logic               s2_live;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_busy <= 1'b0;
    end else begin
      s2_busy <= s1_busy;
    end
    s2_live  <= !s1_done && (s1_count < iter_cap);
    s2_done  <= s1_done || (s1_count >= iter_cap);
    s2_count <= (!s1_done && (s1_count < iter_cap)) ? s1_count + 1'b1 : s1_count;
    s2_zr    <= (!s1_done && (s1_count < iter_cap)) ? nzr : s1_zr;
    s2_zi    <= (!s1_done && (s1_count < iter_cap)) ? nzi : s1_zi;
    erp      <= $signed(nzr) * $signed(nzr);
    eip      <= $signed(nzi) * $signed(nzi);
  end

  always_comb begin
    esum    = 66'(erp >>> FRAC_BITS) + 66'(eip >>> FRAC_BITS);
    escaped = esum >= (66'sd16 <<< FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.busy <= 1'b0;
    end else begin
      tok_out.busy <= s2_busy;
    end
    tok_out.done  <= s2_done || (s2_live && escaped) || (s2_count >= iter_cap);
    tok_out.count <= s2_count;
    tok_out.zr    <= s2_zr;
    tok_out.zi    <= s2_zi;
  end

endmodule

>>> hw/rtl/mandelbrot_escape_time_pixel.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel
// Escape-time evaluator: a pixel token circulates through a ring of cells.
// ----------------------------------------------------------------------------
// operation: a pixel's token makes P passes round a ring of N cells, P =
//   ceil(iterations/N), at least one; one pixel in flight at a time
// handoff: a new pixel is taken only after the last result has left the output
// reset: config registers take their default window and limit, no pixel in flight
module mandelbrot_escape_time_pixel #(
  parameter int unsigned COLS      = 2048,
  parameter int unsigned ROWS      = 1024,
  parameter int unsigned FRAC_BITS = 26,
  parameter int unsigned CELLS     = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  mand_pkg::pixel_in_t    in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output mand_pkg::pixel_out_t   out_data,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_index,
  input  logic [31:0]            cfg_data
);
  import mand_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_COORD, S_RUN, S_OUT} state_t;

  state_t            state;
  logic [31:0]       min_x, min_y;
  logic [30:0]       step_x, step_y;
  logic [15:0]       iter_cap;
  logic [10:0]       col_c;
  logic [9:0]        row_c;
  logic [42:0]       prod_x, prod_y;
  logic [31:0]       cr, ci;
  cell_tok_t         ring [CELLS+1];
  cell_tok_t         inject;
  logic              start;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_x    <= 32'hF706_4C5B;
      min_y    <= 32'hF979_2349;
      step_x   <= 31'd111848;
      step_y   <= 31'd223696;
      iter_cap <= 16'd88;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_X:    min_x    <= cfg_data;
        REG_MIN_Y:    min_y    <= cfg_data;
        REG_STEP_X:   step_x   <= cfg_data[30:0];
        REG_STEP_Y:   step_y   <= cfg_data[30:0];
        REG_ITER_CAP: iter_cap <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      start     <= 1'b0;
    end else begin
      start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_COORD;
          end
        end
        S_COORD: begin
          start <= 1'b1;
          state <= S_RUN;
        end
        S_RUN: begin
          if (ring[CELLS].busy && ring[CELLS].done) begin
            out_valid                <= 1'b1;
            out_data.iteration_count <= ring[CELLS].count;
            out_data.in_set          <= (ring[CELLS].count == iter_cap);
            state                    <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    col_c = (32'(in_data.col) > COLS - 1) ? 11'(COLS - 1) : in_data.col;
    row_c = (32'(in_data.row) > ROWS - 1) ? 10'(ROWS - 1) : in_data.row;
  end

  // clamp and scale in one stage, offset and saturate in the next
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      prod_x <= 43'(col_c) * 43'(step_x);
      prod_y <= 43'(row_c) * 43'(step_y);
    end
    if (state == S_COORD) begin
      cr <= sat32(66'($signed(min_x)) + 66'(prod_x));
      ci <= sat32(66'($signed(min_y)) + 66'(prod_y));
    end
  end

  always_comb begin
    if (start) begin
      inject.busy  = 1'b1;
      inject.done  = 1'b0;
      inject.zr    = '0;
      inject.zi    = '0;
      inject.count = '0;
    end else begin
      inject      = ring[CELLS];
      inject.busy = ring[CELLS].busy && !ring[CELLS].done;
    end
  end

  assign ring[0] = inject;

  for (genvar g = 0; g < CELLS; g++) begin : g_cell
    mand_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .tok_in   (ring[g]),
      .cr       (cr),
      .ci       (ci),
      .iter_cap (iter_cap),
      .tok_out  (ring[g+1])
    );
  end

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the escape-time pixel evaluator against a fixed-point predictor.
// Directed corner and saturation pixels, then random pixels over several
// window settings, with bursty input and a stalling output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import mand_pkg::*;

  localparam int COLS      = 2048;
  localparam int ROWS      = 1024;
  localparam int FRAC_BITS = 26;
  localparam longint CYCLE_LIMIT = 6_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  pixel_in_t   in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  pixel_out_t  out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  mandelbrot_escape_time_pixel i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // window and limit as the block should hold them
  longint win_min_x = -150582181;
  longint win_min_y = -109501623;
  longint win_step_x = 111848;
  longint win_step_y = 223696;
  int     iter_limit = 88;

  pixel_in_t  pixel_queue[$];
  pixel_out_t escape_queue[$];
  int  errors = 0;
  int  pixels_sent = 0;
  int  pixels_seen = 0;
  int  in_set_seen = 0;
  longint cycles = 0;
  bit  hold_armed = 0;
  bit  hold_done = 0;

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic pixel_out_t escape_time(pixel_in_t p);
    longint col, row, cr, ci, zr, zi, rr, ii, ri;
    longint bound;
    int count;
    pixel_out_t r;
    bound = longint'(16) <<< FRAC_BITS;
    col = p.col;
    row = p.row;
    if (col > COLS - 1) col = COLS - 1;
    if (row > ROWS - 1) row = ROWS - 1;
    cr = clip32(win_min_x + col * win_step_x);
    ci = clip32(win_min_y + row * win_step_y);
    zr = 0;
    zi = 0;
    count = 0;
    while (count < iter_limit) begin
      rr = (zr * zr) >>> FRAC_BITS;
      ii = (zi * zi) >>> FRAC_BITS;
      ri = (zr * zi) >>> (FRAC_BITS - 1);
      zr = clip32(rr - ii + cr);
      zi = clip32(ri + ci);
      count++;
      rr = (zr * zr) >>> FRAC_BITS;
      ii = (zi * zi) >>> FRAC_BITS;
      if (rr + ii >= bound) break;
    end
    r.iteration_count = count[15:0];
    r.in_set = (count == iter_limit);
    return r;
  endfunction

  // driver: bursts of transactions with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        escape_queue.push_back(escape_time(pixel_queue[0]));
        void'(pixel_queue.pop_front());
        pixels_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pixel_queue.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= pixel_queue[0];
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 20);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random stall pattern, one long hold-off, compare results
  int stall_left = 0;
  int free_left = 0;
  int hold_cnt = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles", $time, cycles);
      $display("FAIL");
      $finish;
    end
    if (!rst) begin
      if (out_valid && !out_stall) begin
        pixels_seen++;
        if (escape_queue.size() == 0) begin
          $display("%0t unexpected result: expected none, actual %0d/%0b", $time,
                   out_data.iteration_count, out_data.in_set);
          errors++;
        end else begin
          if (out_data.iteration_count !== escape_queue[0].iteration_count) begin
            $display("%0t iteration_count: expected %0d, actual %0d", $time,
                     escape_queue[0].iteration_count, out_data.iteration_count);
            errors++;
          end
          if (out_data.in_set !== escape_queue[0].in_set) begin
            $display("%0t in_set: expected %0b, actual %0b", $time,
                     escape_queue[0].in_set, out_data.in_set);
            errors++;
          end
          if (escape_queue[0].in_set) in_set_seen++;
          void'(escape_queue.pop_front());
        end
      end
      if (hold_armed && !hold_done && hold_cnt == 0) begin
        hold_cnt = 800;
        hold_done = 1;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (free_left > 0) begin
        free_left--;
        out_stall <= 1'b0;
      end else begin
        free_left = $urandom_range(1, 40);
        stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_MIN_X:    win_min_x = longint'(signed'(val));
      REG_MIN_Y:    win_min_y = longint'(signed'(val));
      REG_STEP_X:   win_step_x = longint'(val[30:0]);
      REG_STEP_Y:   win_step_y = longint'(val[30:0]);
      REG_ITER_CAP: iter_limit = val[15:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_window(logic [31:0] mx, logic [31:0] my, logic [31:0] sx,
                            logic [31:0] sy, logic [31:0] lim);
    write_reg(REG_MIN_X, mx);
    write_reg(REG_MIN_Y, my);
    write_reg(REG_STEP_X, sx);
    write_reg(REG_STEP_Y, sy);
    write_reg(REG_ITER_CAP, lim);
  endtask

  task automatic add_pixel(int c, int r);
    pixel_in_t p;
    p.col = c[10:0];
    p.row = r[9:0];
    pixel_queue.push_back(p);
  endtask

  task automatic drain();
    while (pixel_queue.size() > 0 || escape_queue.size() > 0 || in_valid)
      @(posedge clk);
    repeat (3 + 12 * ((iter_limit + 3) / 4) + 10) @(posedge clk);
  endtask

  task automatic random_pixels(int n);
    repeat (n) add_pixel($urandom_range(0, 2047), $urandom_range(0, 1023));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset window: corners, center and alternating bit patterns
    add_pixel(0, 0);       add_pixel(2047, 1023);
    add_pixel(0, 1023);    add_pixel(2047, 0);
    add_pixel(1024, 512);  add_pixel(1350, 490);
    add_pixel(1365, 682);  add_pixel(682, 341);
    add_pixel(900, 450);   add_pixel(1600, 300);
    drain();

    // extreme window: c saturates, limit of one
    set_window(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
    add_pixel(0, 0); add_pixel(2047, 1023); add_pixel(1, 0); add_pixel(0, 1);
    drain();

    // zero limit
    write_reg(REG_ITER_CAP, 0);
    add_pixel(5, 7); add_pixel(2047, 1023);
    drain();

    // largest limit: origin and cusp stay bounded, far pixel escapes;
    // stray index ignored
    set_window(0, 0, 32'h0100_0000, 0, 65535);
    write_reg(3'd5, 32'hFFFF_FFFF);
    write_reg(3'd7, 32'h1234_5678);
    add_pixel(0, 0); add_pixel(1, 0); add_pixel(2047, 0);
    drain();

    // random windows around the set, one phase with a long hold-off
    for (int ph = 0; ph < 6; ph++) begin
      set_window(-32'sd167772160 + $urandom_range(0, 33554432),
                 -32'sd100663296 + $urandom_range(0, 33554432),
                 $urandom_range(0, 1 << 18), $urandom_range(0, 1 << 19),
                 $urandom_range(1, 120));
      if (ph == 2) hold_armed = 1;
      random_pixels(220);
      drain();
    end

    // fully random registers with a small limit, then random offsets with small steps
    set_window($urandom, $urandom, $urandom, $urandom, $urandom_range(1, 16));
    random_pixels(150);
    drain();
    set_window($urandom, $urandom, $urandom_range(0, 1 << 12),
               $urandom_range(0, 1 << 12), 16'hFFFF & $urandom_range(1, 40));
    random_pixels(60);
    drain();

    $display("covered %0d pixels (%0d inside the set) over saturating, zero-limit,",
             pixels_seen, in_set_seen);
    $display("full-limit and random windows with bursty input and output stalls");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
